FILE: rtl/sha_pkg.sv
// Package with shared types, constants and the round constant table for the SHA-256 hasher.
package sha_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumHash = 8;
  localparam int unsigned NumBuf  = 16;
  localparam int unsigned NumRnd  = 64;
  localparam int unsigned CntW    = 61;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [WordW-1:0] HashInit [NumHash] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMP,
    ST_OUT
  } state_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t k_const(input logic [5:0] i);
    word_t k;
    unique case (i)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    k_const = k;
  endfunction

endpackage

FILE: rtl/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher: byte packing, padding control and digest output.
// A byte request is accepted whenever the block is idle; the byte that completes a 64-byte block
// starts a compression of 64 rounds in the shared round unit, one round per cycle, and input is
// stalled until the chaining value is updated. An end request runs one or two such compressions
// (two when fewer than 8 bytes of room remain after the 0x80 byte) and then delivers the eight
// digest words, word 0 first, one per accepted output cycle, after which the block returns to its
// initial state.
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha_pkg::*;

  state_t          state_r, state_nxt;
  word_t           hash_r   [NumHash];
  word_t           hash_nxt [NumHash];
  word_t           buf_r    [NumBuf];
  word_t           buf_nxt  [NumBuf];
  logic [5:0]      pos_r, pos_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            end_r, end_nxt;
  logic            second_r, second_nxt;
  logic            start_r, start_nxt;
  logic [2:0]      idx_r, idx_nxt;

  logic            core_busy, core_done;
  word_t           core_vars [NumHash];
  logic            in_acc, out_acc;
  logic [63:0]     bit_len;
  logic [7:0]      wr_byte;
  logic [3:0]      wr_word;
  logic [4:0]      wr_sh;

  sha_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .hash_in  (hash_r),
    .block_in (buf_r),
    .busy     (core_busy),
    .done     (core_done),
    .vars_out (core_vars)
  );

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign bit_len = {cnt_r, 3'b000};
  assign wr_byte = in_kind ? PadByte : in_data_byte;
  assign wr_word = pos_r[5:2];
  assign wr_sh   = {~pos_r[1:0], 3'b000};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc && (in_kind || pos_r == 6'd63)) state_nxt = ST_COMP;
      ST_COMP: if (core_done && !(end_r && second_r)) state_nxt = end_r ? ST_OUT : ST_IDLE;
      ST_OUT:  if (out_acc && idx_r == 3'd7) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall        = (state_r != ST_IDLE);
    out_valid       = (state_r == ST_OUT);
    out_digest_word = hash_r[idx_r];
    out_word_index  = idx_r;
    out_last_word   = (idx_r == 3'd7);
  end

  // Datapath updates.
  always_comb begin
    hash_nxt   = hash_r;
    buf_nxt    = buf_r;
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    end_nxt    = end_r;
    second_nxt = second_r;
    start_nxt  = 1'b0;
    idx_nxt    = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          buf_nxt[wr_word] = (buf_r[wr_word] & ~(word_t'(8'hff) << wr_sh))
                           | (word_t'(wr_byte) << wr_sh);
          pos_nxt = pos_r + 6'd1;
          if (!in_kind) begin
            cnt_nxt = cnt_r + CntW'(1);
            end_nxt = 1'b0;
            if (pos_r == 6'd63) start_nxt = 1'b1;
          end else begin
            end_nxt   = 1'b1;
            start_nxt = 1'b1;
            // No room for the length: compress this block, then a length-only block.
            if (pos_r >= 6'd56) begin
              second_nxt = 1'b1;
            end else begin
              second_nxt  = 1'b0;
              buf_nxt[14] = bit_len[63:32];
              buf_nxt[15] = bit_len[31:0];
            end
          end
        end
      end
      ST_COMP: begin
        if (core_done) begin
          for (int i = 0; i < NumHash; i++) hash_nxt[i] = hash_r[i] + core_vars[i];
          for (int i = 0; i < NumBuf; i++) buf_nxt[i] = '0;
          idx_nxt = '0;
          if (end_r && second_r) begin
            buf_nxt[14] = bit_len[63:32];
            buf_nxt[15] = bit_len[31:0];
            second_nxt  = 1'b0;
            start_nxt   = 1'b1;
          end
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            hash_nxt = HashInit;
            cnt_nxt  = '0;
            pos_nxt  = '0;
            end_nxt  = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      hash_r   <= HashInit;
      for (int i = 0; i < NumBuf; i++) buf_r[i] <= '0;
      pos_r    <= '0;
      cnt_r    <= '0;
      end_r    <= 1'b0;
      second_r <= 1'b0;
      start_r  <= 1'b0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      hash_r   <= hash_nxt;
      buf_r    <= buf_nxt;
      pos_r    <= pos_nxt;
      cnt_r    <= cnt_nxt;
      end_r    <= end_nxt;
      second_r <= second_nxt;
      start_r  <= start_nxt;
      idx_r    <= idx_nxt;
    end
  end

`ifndef SYNTHESIS
  a_start_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> state_r == ST_COMP) else $error("compression started outside compress state");
  a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_word_index == 3'd0) else $error("digest does not start at word 0");
  a_out_no_core: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !core_busy && in_stall) else $error("digest out while hashing");
`endif

endmodule

FILE: rtl/sha_core.sv
// Shared SHA-256 round unit: one compression round per cycle over the 64 rounds.
module sha_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  sha_pkg::word_t    hash_in  [sha_pkg::NumHash],
  input  sha_pkg::word_t    block_in [sha_pkg::NumBuf],
  output logic              busy,
  output logic              done,
  output sha_pkg::word_t    vars_out [sha_pkg::NumHash]
);
  import sha_pkg::*;

  word_t      v_r   [NumHash];
  word_t      v_nxt [NumHash];
  word_t      w_r   [NumBuf];
  word_t      w_nxt [NumBuf];
  logic [5:0] rnd_r;
  logic       busy_r;
  logic       done_r;

  word_t t1, t2, s0, s1, w_new;

  always_comb begin
    s0    = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1    = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = s1 + w_r[9] + s0 + w_r[0];
    t1 = v_r[7] + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25))
       + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + k_const(rnd_r) + w_r[0];
    t2 = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22))
       + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    v_nxt[0] = t1 + t2;
    v_nxt[1] = v_r[0];
    v_nxt[2] = v_r[1];
    v_nxt[3] = v_r[2];
    v_nxt[4] = v_r[3] + t1;
    v_nxt[5] = v_r[4];
    v_nxt[6] = v_r[5];
    v_nxt[7] = v_r[6];
    for (int i = 0; i < NumBuf - 1; i++) w_nxt[i] = w_r[i+1];
    w_nxt[NumBuf-1] = w_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == 6'(NumRnd - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r <= hash_in;
      w_r <= block_in;
    end else if (busy_r) begin
      v_r <= v_nxt;
      w_r <= w_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign vars_out = v_r;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start) else $error("compression restarted while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done raised while busy");
  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(rnd_r) == 6'(NumRnd - 1)) else $error("done not after last round");
`endif

endmodule

FILE: sim/sha256_checker.sv
// Checker for the SHA-256 hasher: predicts digests from accepted requests and compares outputs.
module sha256_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word,
  output int          fail_count,
  output int          pending_words,
  output int          digest_count
);
  import sha_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_entry_t;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] StartHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [31:0]   chain [8];
  logic [31:0]   msg_block [16];
  logic [5:0]    slot;
  logic [60:0]   byte_total;
  digest_entry_t digest_q [$];

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic clear_state();
    for (int i = 0; i < 8; i++) chain[i] = StartHash[i];
    for (int i = 0; i < 16; i++) msg_block[i] = '0;
    slot = '0;
    byte_total = '0;
  endtask

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++) w[t] = msg_block[t];
    for (int t = 16; t < 64; t++) begin
      s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    for (int t = 0; t < 8; t++) v[t] = chain[t];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[r] + w[r];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int t = 0; t < 8; t++) chain[t] += v[t];
    for (int t = 0; t < 16; t++) msg_block[t] = '0;
  endtask

  task automatic pack_byte(logic [7:0] b);
    int sh;
    sh = (3 - slot[1:0]) * 8;
    msg_block[slot[5:2]] = (msg_block[slot[5:2]] & ~(32'hff << sh)) | ({24'h0, b} << sh);
    slot = slot + 1'b1;
    if (slot == 0) compress();
  endtask

  task automatic finish_message();
    logic [63:0] bits;
    digest_entry_t e;
    bits = {byte_total, 3'b000};
    pack_byte(PadByte);
    if (slot > 56) while (slot != 0) pack_byte(8'h00);
    msg_block[14] = bits[63:32];
    msg_block[15] = bits[31:0];
    compress();
    for (int i = 0; i < 8; i++) begin
      e.word = chain[i];
      e.idx = i[2:0];
      e.last = (i == 7);
      digest_q.push_back(e);
    end
    clear_state();
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    digest_count = 0;
    clear_state();
  end

  assign pending_words = digest_q.size();

  always @(posedge clk) begin
    digest_entry_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          report("unexpected word", out_digest_word, 32'h0);
        end else begin
          e = digest_q.pop_front();
          if (out_digest_word !== e.word) report("digest_word", out_digest_word, e.word);
          if (out_word_index !== e.idx) report("word_index", out_word_index, e.idx);
          if (out_last_word !== e.last) report("last_word", out_last_word, e.last);
          if (e.last) digest_count++;
        end
      end
      if (in_valid && !in_stall) begin
        if (in_kind) begin
          finish_message();
        end else begin
          byte_total = byte_total + 1'b1;
          pack_byte(in_data_byte);
        end
      end
    end
  end
endmodule

FILE: sim/tb.sv
// Testbench top for the SHA-256 hasher: stimulus, back-pressure and the final verdict.
module tb;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_kind = 1'b0;
  logic [7:0]  in_data_byte = '0;
  logic        out_stall = 1'b0;
  logic        in_stall, out_valid, out_last_word;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  int          fail_count, pending_words, digest_count;
  int          cycles = 0;
  int          sent = 0;
  int          rx_mode = 0;
  int          hold_left = 0;
  bit          no_idle = 1'b0;

  localparam int CycleLimit = 400000;

  sha256_byte_stream_hasher dut (.*);

  sha256_checker chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off while the sender keeps pushing.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (rx_mode == 1) begin
      hold_left <= 400;
      rx_mode <= 2;
      out_stall <= 1'b1;
    end else begin
      out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 33);
    end
  end

  // Offers one request and holds it until it is taken; valid drops only on idle cycles.
  task automatic send(logic kind, logic [7:0] b);
    while (!no_idle && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_message(int len, int style);
    for (int i = 0; i < len; i++)
      send(1'b0, style == 0 ? 8'h00 : style == 1 ? 8'hff : 8'($urandom_range(255)));
    send(1'b1, 8'($urandom_range(255)));
  endtask

  initial begin
    int len;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    // Directed: empty message, padding boundaries, extremes of the byte.
    send(1'b1, 8'hff);
    send_message(3, 2);
    send_message(55, 0);
    send_message(56, 1);
    send_message(64, 2);
    send(1'b1, 8'h00);
    // Random messages; one stretch runs without idling, one with a long hold-off.
    while (sent < 450) begin
      no_idle = (sent > 200 && sent < 300);
      if (sent > 320 && rx_mode == 0) rx_mode = 1;
      len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(12);
      send_message(len, ($urandom_range(7) == 0) ? $urandom_range(1) : 2);
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;
    while (pending_words != 0 || hold_left != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d requests, checked %0d digests", sent, digest_count);
    if (fail_count == 0 && pending_words == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
